/* hdl/pareto_front_archive_defines.svh */
// assertion macros used by the pareto front archive checker
`ifndef PARETO_FRONT_ARCHIVE_DEFINES_SVH
`define PARETO_FRONT_ARCHIVE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PFA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pareto front archive check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PFA_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pareto front archive check failed");

`endif

/* hdl/pfa_pkg.sv */
// shared types and constants of the pareto front archive
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic [31:0] cost;
    logic [15:0] rel;
    logic [15:0] tag;
  } entry_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic             shift;
    logic             write;
    logic [IDX_W-1:0] widx;
    entry_t           wdata;
  } cell_ctl_t;

  typedef struct packed {
    logic        accepted;
    logic        dominated;
    logic        overflow;
    logic [4:0]  removed_count;
    logic [4:0]  front_size;
    logic        read_valid;
    logic [31:0] read_cost;
    logic [15:0] read_reliability;
    logic [15:0] read_tag;
  } result_t;

endpackage

/* hdl/pfa_cell.sv */
// one archive cell: holds an entry, takes its neighbor's on shift or a direct write
`timescale 1ns / 1ps

module pfa_cell (
  input  logic                         clk_i,
  input  pfa_pkg::cell_ctl_t           ctl_i,
  input  logic [pfa_pkg::IDX_W-1:0]    idx_i,
  input  pfa_pkg::entry_t              nbr_i,
  output pfa_pkg::entry_t              entry_o
);

  pfa_pkg::entry_t entry_q;
  pfa_pkg::entry_t entry_d;

  // a write aimed at this cell wins over the shift
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.write && (ctl_i.widx == idx_i)) begin
      entry_d = ctl_i.wdata;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* hdl/pfa_scan.sv */
// scan sequencer: dominance test at the head of the row, compaction, append and result
`timescale 1ns / 1ps

module pfa_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [31:0]                 new_cost_i,
  input  logic [15:0]                 new_reliability_i,
  input  logic [15:0]                 new_tag_i,
  input  logic [3:0]                  read_index_i,
  input  pfa_pkg::entry_t             head_i,
  input  pfa_pkg::entry_t             rd_entry_i,
  output logic [3:0]                  rd_index_o,
  output pfa_pkg::cell_ctl_t          ctl_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pfa_pkg::result_t            res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  localparam logic [pfa_pkg::CNT_W-1:0] CNT_ONE = pfa_pkg::CNT_W'(1);
  localparam logic [pfa_pkg::CNT_W-1:0] CNT_CAP = pfa_pkg::CNT_W'(pfa_pkg::CAPACITY);

  state_e                      state_q;
  logic                        mode_q;
  logic [31:0]                 cost_q;
  logic [15:0]                 rel_q;
  logic [15:0]                 tag_q;
  logic [3:0]                  ridx_q;
  logic [pfa_pkg::CNT_W-1:0]   count_q;
  logic [pfa_pkg::CNT_W-1:0]   n_q;
  logic [pfa_pkg::CNT_W-1:0]   j_q;
  logic [pfa_pkg::CNT_W-1:0]   removed_q;
  logic [pfa_pkg::IDX_W-1:0]   wp_q;
  logic                        stop_q;
  logic                        out_valid_q;
  pfa_pkg::result_t            res_q;
  pfa_pkg::result_t            res_d;

  logic                        step_dom;
  logic                        step_drop;
  logic                        keep;
  logic                        fire;
  logic [pfa_pkg::CNT_W-1:0]   new_cnt;
  logic                        fits;
  logic                        ins_ok;
  logic                        rd_ok;

  // dominance test against the entry at the head of the row
  assign step_dom  = (cost_q >= head_i.cost) && (rel_q <= head_i.rel);
  assign step_drop = (cost_q <= head_i.cost) && (rel_q >= head_i.rel);
  assign keep      = stop_q || step_dom || !step_drop;

  // finishing values
  assign new_cnt = n_q - removed_q;
  assign fits    = new_cnt < CNT_CAP;
  assign ins_ok  = !stop_q && fits;
  assign rd_ok   = {{pfa_pkg::CNT_W{1'b0}}, ridx_q} < {4'b0000, count_q};
  assign fire    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // cell row control: rotate through the head, write kept entries back, append at the end
  always_comb begin
    ctl_o = '0;
    if (state_q == ST_SCAN) begin
      ctl_o.shift = 1'b1;
      ctl_o.write = keep;
      ctl_o.widx  = wp_q;
      ctl_o.wdata = head_i;
    end else if (fire && (mode_q == pfa_pkg::MODE_INSERT) && ins_ok) begin
      ctl_o.write      = 1'b1;
      ctl_o.widx       = pfa_pkg::IDX_W'(new_cnt);
      ctl_o.wdata.cost = cost_q;
      ctl_o.wdata.rel  = rel_q;
      ctl_o.wdata.tag  = tag_q;
    end
  end

  // result of the item in its last cycle
  always_comb begin
    res_d = '0;
    if (mode_q == pfa_pkg::MODE_INSERT) begin
      res_d.accepted      = ins_ok;
      res_d.dominated     = stop_q;
      res_d.overflow      = !stop_q && !fits;
      res_d.removed_count = 5'(removed_q);
      if (ins_ok) begin
        res_d.front_size = 5'(new_cnt + CNT_ONE);
      end else begin
        res_d.front_size = 5'(new_cnt);
      end
    end else begin
      res_d.front_size = 5'(count_q);
      res_d.read_valid = rd_ok;
      if (rd_ok) begin
        res_d.read_cost        = rd_entry_i.cost;
        res_d.read_reliability = rd_entry_i.rel;
        res_d.read_tag         = rd_entry_i.tag;
      end
    end
  end

  // sequencer state, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= pfa_pkg::MODE_INSERT;
      cost_q      <= '0;
      rel_q       <= '0;
      tag_q       <= '0;
      ridx_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
      j_q         <= '0;
      removed_q   <= '0;
      wp_q        <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (!out_stall_i && !fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q    <= mode_i;
            cost_q    <= new_cost_i;
            rel_q     <= new_reliability_i;
            tag_q     <= new_tag_i;
            ridx_q    <= read_index_i;
            n_q       <= count_q;
            j_q       <= '0;
            removed_q <= '0;
            wp_q      <= pfa_pkg::IDX_W'(count_q - CNT_ONE);
            stop_q    <= 1'b0;
            if ((mode_i == pfa_pkg::MODE_INSERT) && (count_q != '0)) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (!stop_q && step_dom) begin
            stop_q <= 1'b1;
          end
          if (!keep) begin
            removed_q <= removed_q + CNT_ONE;
            wp_q      <= wp_q - pfa_pkg::IDX_W'(1);
          end
          j_q <= j_q + CNT_ONE;
          if (j_q == (n_q - CNT_ONE)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            res_q       <= res_d;
            if (mode_q == pfa_pkg::MODE_INSERT) begin
              if (ins_ok) begin
                count_q <= new_cnt + CNT_ONE;
              end else begin
                count_q <= new_cnt;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign rd_index_o  = ridx_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/pareto_front_archive.sv */
// pareto front archive top level: row of entry cells and the scan sequencer
//
// Keeps an ordered archive of up to CAPACITY non-dominated points (cost
// smaller is better, reliability larger is better) with a tag for each.
// Input channel: in_valid_i / in_stall_o with mode, candidate point and
// read index; an item is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i, one result item per input item.
// An insert rotates the whole row once through the head cell, where the
// candidate is compared with each stored entry; kept entries are written
// back in order, dominated ones are squeezed out, and the candidate is
// appended in a last cycle. An insert into a non-empty archive runs the
// scan state and then the finish state, where its result is registered; a
// read, or an insert into an empty archive, goes straight to the finish
// state. The block holds one item at a time and takes a new item the cycle
// after the result is registered; the rotation moves one entry per cycle.
// A result waiting under out_stall_i is held; the next item may still be
// taken and runs its scan, then waits in its last cycle for the slot.
// Reset empties the archive (the entry count goes to zero) and clears the
// output valid; entry contents are not cleared.
`timescale 1ns / 1ps

module pareto_front_archive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] new_cost_i,
  input  logic [15:0] new_reliability_i,
  input  logic [15:0] new_tag_i,
  input  logic [3:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        dominated_o,
  output logic        overflow_o,
  output logic [4:0]  removed_count_o,
  output logic [4:0]  front_size_o,
  output logic        read_valid_o,
  output logic [31:0] read_cost_o,
  output logic [15:0] read_reliability_o,
  output logic [15:0] read_tag_o
);

  pfa_pkg::entry_t    cell_q [pfa_pkg::CAPACITY];
  pfa_pkg::cell_ctl_t ctl;
  pfa_pkg::entry_t    rd_entry;
  pfa_pkg::result_t   res;
  logic [3:0]         rd_index;

  // row of cells, each shifting toward the head
  for (genvar k = 0; k < pfa_pkg::CAPACITY; k++) begin : g_cell
    if (k == pfa_pkg::CAPACITY - 1) begin : g_last
      pfa_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (pfa_pkg::IDX_W'(k)),
        .nbr_i   (cell_q[k]),
        .entry_o (cell_q[k])
      );
    end else begin : g_mid
      pfa_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (pfa_pkg::IDX_W'(k)),
        .nbr_i   (cell_q[k + 1]),
        .entry_o (cell_q[k])
      );
    end
  end

  // read port by position
  assign rd_entry = cell_q[pfa_pkg::IDX_W'(rd_index)];

  pfa_scan u_scan (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .new_cost_i        (new_cost_i),
    .new_reliability_i (new_reliability_i),
    .new_tag_i         (new_tag_i),
    .read_index_i      (read_index_i),
    .head_i            (cell_q[0]),
    .rd_entry_i        (rd_entry),
    .rd_index_o        (rd_index),
    .ctl_o             (ctl),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .res_o             (res)
  );

  // result fields
  assign accepted_o         = res.accepted;
  assign dominated_o        = res.dominated;
  assign overflow_o         = res.overflow;
  assign removed_count_o    = res.removed_count;
  assign front_size_o       = res.front_size;
  assign read_valid_o       = res.read_valid;
  assign read_cost_o        = res.read_cost;
  assign read_reliability_o = res.read_reliability;
  assign read_tag_o         = res.read_tag;

endmodule

/* hdl/pfa_checker.sv */
// port-level checker of the pareto front archive, bound to the top level
`timescale 1ns / 1ps
`include "pareto_front_archive_defines.svh"

module pfa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] new_cost_i,
  input  logic [15:0] new_reliability_i,
  input  logic [15:0] new_tag_i,
  input  logic [3:0]  read_index_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        accepted_o,
  input  logic        dominated_o,
  input  logic        overflow_o,
  input  logic [4:0]  removed_count_o,
  input  logic [4:0]  front_size_o,
  input  logic        read_valid_o,
  input  logic [31:0] read_cost_o,
  input  logic [15:0] read_reliability_o,
  input  logic [15:0] read_tag_o
);

  // one item at a time: busy right after an item is taken
  `PFA_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // an insert ends in at most one of its outcomes
  `PFA_ASSERT_IMP(a_one_outcome, out_valid_o,
    !(accepted_o && dominated_o) && !(accepted_o && overflow_o) && !(dominated_o && overflow_o))

  // a successful read carries no insert outcome
  `PFA_ASSERT_IMP(a_read_clean, out_valid_o && read_valid_o,
    !accepted_o && !dominated_o && !overflow_o && (removed_count_o == 5'd0))

  // a stalled result holds
  `PFA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(front_size_o) && $stable(accepted_o) && $stable(read_cost_o))

endmodule

bind pareto_front_archive pfa_checker u_pfa_checker (.*);

/* tb/sv/tb_pareto_front_archive.sv */
// self-checking testbench for the pareto front archive: directed rows, then random items
`timescale 1ns / 1ps

module tb_pareto_front_archive;

  localparam int RANDOM_ITEMS = 1250;
  localparam int PAUSE_AT     = 600;
  localparam int STEADY_FIRST = 300;
  localparam int STEADY_LAST  = 550;
  localparam int IDLE_PCT     = 14;
  localparam int STUCK_LIMIT  = 4000;

  // one input item as the sender sees it
  typedef struct {
    logic        mode;
    logic [31:0] cost;
    logic [15:0] rel;
    logic [15:0] tag;
    logic [3:0]  index;
  } cand_t;

  // one row of the directed table; want is only used where typed is set
  typedef struct {
    cand_t            item;
    bit               typed;
    pfa_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = pfa_pkg::MODE_INSERT;
  logic [31:0] new_cost = '0;
  logic [15:0] new_reliability = '0;
  logic [15:0] new_tag = '0;
  logic [3:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        dominated;
  logic        overflow;
  logic [4:0]  removed_count;
  logic [4:0]  front_size;
  logic        read_valid;
  logic [31:0] read_cost;
  logic [15:0] read_reliability;
  logic [15:0] read_tag;

  // predicted archive contents
  logic [31:0] front_cost [pfa_pkg::CAPACITY];
  logic [15:0] front_rel [pfa_pkg::CAPACITY];
  logic [15:0] front_tag [pfa_pkg::CAPACITY];
  int          front_count = 0;

  pfa_pkg::result_t pending_results[$];
  stim_row_t        directed_rows[$];
  int               err_count = 0;
  int               stuck_cycles = 0;
  bit               steady = 1'b0;

  pareto_front_archive uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .mode_i             (mode),
    .new_cost_i         (new_cost),
    .new_reliability_i  (new_reliability),
    .new_tag_i          (new_tag),
    .read_index_i       (read_index),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .accepted_o         (accepted),
    .dominated_o        (dominated),
    .overflow_o         (overflow),
    .removed_count_o    (removed_count),
    .front_size_o       (front_size),
    .read_valid_o       (read_valid),
    .read_cost_o        (read_cost),
    .read_reliability_o (read_reliability),
    .read_tag_o         (read_tag)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one item to the predicted archive and return its result
  function automatic pfa_pkg::result_t apply_to_front(input cand_t c);
    pfa_pkg::result_t r;
    int               pos;
    int               k;
    bit               keep;
    r = '0;
    if (c.mode == pfa_pkg::MODE_INSERT) begin
      pos = 0;
      keep = 1'b1;
      while (keep && pos < front_count) begin
        if (c.cost >= front_cost[pos] && c.rel <= front_rel[pos]) begin
          keep = 1'b0;
        end else if (c.cost <= front_cost[pos] && c.rel >= front_rel[pos]) begin
          // squeeze out the dominated entry, order kept
          for (k = pos; k + 1 < front_count; k++) begin
            front_cost[k] = front_cost[k + 1];
            front_rel[k]  = front_rel[k + 1];
            front_tag[k]  = front_tag[k + 1];
          end
          front_count--;
          r.removed_count = r.removed_count + 5'd1;
        end else begin
          pos++;
        end
      end
      if (!keep) begin
        r.dominated = 1'b1;
      end else if (front_count < pfa_pkg::CAPACITY) begin
        front_cost[front_count] = c.cost;
        front_rel[front_count]  = c.rel;
        front_tag[front_count]  = c.tag;
        front_count++;
        r.accepted = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
    end else if (int'(c.index) < front_count) begin
      r.read_valid       = 1'b1;
      r.read_cost        = front_cost[c.index];
      r.read_reliability = front_rel[c.index];
      r.read_tag         = front_tag[c.index];
    end
    r.front_size = front_count[4:0];
    return r;
  endfunction

  function automatic cand_t insert_item(input logic [31:0] cost, input logic [15:0] rel,
                                        input logic [15:0] tag);
    cand_t c;
    c.mode  = pfa_pkg::MODE_INSERT;
    c.cost  = cost;
    c.rel   = rel;
    c.tag   = tag;
    c.index = '0;
    return c;
  endfunction

  function automatic cand_t read_item(input logic [3:0] index);
    cand_t c;
    c.mode  = pfa_pkg::MODE_READ;
    c.cost  = '0;
    c.rel   = '0;
    c.tag   = '0;
    c.index = index;
    return c;
  endfunction

  function automatic pfa_pkg::result_t outcome(input logic acc, input logic dom,
                                               input logic ovf,
                                               input logic [4:0] removed,
                                               input logic [4:0] size,
                                               input logic rv, input logic [31:0] rc,
                                               input logic [15:0] rr,
                                               input logic [15:0] rt);
    pfa_pkg::result_t r;
    r.accepted         = acc;
    r.dominated        = dom;
    r.overflow         = ovf;
    r.removed_count    = removed;
    r.front_size       = size;
    r.read_valid       = rv;
    r.read_cost        = rc;
    r.read_reliability = rr;
    r.read_tag         = rt;
    return r;
  endfunction

  function automatic void add_row(input cand_t item, input bit typed,
                                  input pfa_pkg::result_t want);
    stim_row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // random item: mostly a small step off a stored point, some reads, some noise
  function automatic cand_t random_candidate();
    cand_t       c;
    int unsigned sel;
    int          pick;
    int          dc;
    int          dr;
    longint      lc;
    longint      lr;
    c.mode  = pfa_pkg::MODE_INSERT;
    c.cost  = $urandom;
    c.rel   = 16'($urandom);
    c.tag   = 16'($urandom);
    c.index = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      c.mode = pfa_pkg::MODE_READ;
    end else if (sel < 88 && front_count > 0) begin
      pick = $urandom_range(0, front_count - 1);
      dc = int'($urandom_range(0, 8191)) - 4096;
      dr = int'($urandom_range(0, 255)) - 128;
      lc = longint'(front_cost[pick]) + dc;
      lr = longint'(front_rel[pick]) + dr;
      if (lc < 0) lc = 0;
      if (lc > longint'(32'hFFFF_FFFF)) lc = longint'(32'hFFFF_FFFF);
      if (lr < 0) lr = 0;
      if (lr > longint'(16'hFFFF)) lr = longint'(16'hFFFF);
      c.cost = lc[31:0];
      c.rel  = lr[15:0];
    end
    return c;
  endfunction

  // present one item, hold it until taken, then record its expected result
  task automatic send_item(input cand_t c, input bit typed, input pfa_pkg::result_t want);
    pfa_pkg::result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= c.mode;
    new_cost        <= c.cost;
    new_reliability <= c.rel;
    new_tag         <= c.tag;
    read_index      <= c.index;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_front(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // result side: compare each taken item, then pick the next stall
  always @(posedge clk) begin
    pfa_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("dominated", 32'(want.dominated), 32'(dominated));
          check_field("overflow", 32'(want.overflow), 32'(overflow));
          check_field("removed_count", 32'(want.removed_count), 32'(removed_count));
          check_field("front_size", 32'(want.front_size), 32'(front_size));
          check_field("read_valid", 32'(want.read_valid), 32'(read_valid));
          check_field("read_cost", want.read_cost, read_cost);
          check_field("read_reliability", 32'(want.read_reliability),
                      32'(read_reliability));
          check_field("read_tag", 32'(want.read_tag), 32'(read_tag));
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("pareto_front_archive regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n;
    int k;
    // empty archive, first point, equal point, read past the end
    add_row(read_item(4'd0), 1'b1,
            outcome(1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(insert_item(32'h0010_0000, 16'h8000, 16'h0001), 1'b1,
            outcome(1'b1, 1'b0, 1'b0, 5'd0, 5'd1, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(insert_item(32'h0010_0000, 16'h8000, 16'h0055), 1'b1,
            outcome(1'b0, 1'b1, 1'b0, 5'd0, 5'd1, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(read_item(4'd15), 1'b1,
            outcome(1'b0, 1'b0, 1'b0, 5'd0, 5'd1, 1'b0, 32'd0, 16'd0, 16'd0));
    // fill the archive with a rising staircase
    add_row(insert_item(32'h0008_0000, 16'h4000, 16'h0002), 1'b0, '0);
    add_row(insert_item(32'h0020_0000, 16'hC000, 16'h0003), 1'b0, '0);
    for (k = 0; k < 13; k++) begin
      add_row(insert_item(32'(32'h0030_0000 + k * 32'h0010_0000),
                          16'(16'hC100 + k * 16'h0100), 16'(16'h0100 + k)), 1'b0, '0);
    end
    // full archive drops a surviving point
    add_row(insert_item(32'h0100_0000, 16'hFF00, 16'h0200), 1'b1,
            outcome(1'b0, 1'b0, 1'b1, 5'd0, 5'd16, 1'b0, 32'd0, 16'd0, 16'd0));
    // one point clears every entry
    add_row(insert_item(32'h0008_0000, 16'hCD00, 16'h0300), 1'b1,
            outcome(1'b1, 1'b0, 1'b0, 5'd16, 5'd1, 1'b0, 32'd0, 16'd0, 16'd0));
    // field extremes
    add_row(insert_item(32'hFFFF_FFFF, 16'h0000, 16'hAAAA), 1'b1,
            outcome(1'b0, 1'b1, 1'b0, 5'd0, 5'd1, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(insert_item(32'h0000_0000, 16'h0000, 16'h0000), 1'b1,
            outcome(1'b1, 1'b0, 1'b0, 5'd0, 5'd2, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(insert_item(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF), 1'b1,
            outcome(1'b1, 1'b0, 1'b0, 5'd0, 5'd3, 1'b0, 32'd0, 16'd0, 16'd0));
    add_row(read_item(4'd0), 1'b1,
            outcome(1'b0, 1'b0, 1'b0, 5'd0, 5'd3, 1'b1, 32'h0008_0000, 16'hCD00, 16'h0300));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // random part, with a stretch of back-to-back traffic and one full pause
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= STEADY_FIRST && n < STEADY_LAST);
      if (n == PAUSE_AT) drain_results();
      send_item(random_candidate(), 1'b0, '0);
    end
    steady = 1'b0;
    drain_results();
    repeat (pfa_pkg::CAPACITY + 8) @(posedge clk);

    if (err_count == 0) begin
      $display("pareto_front_archive regression: pass");
    end else begin
      $display("pareto_front_archive regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_cell.sv
hdl/pfa_scan.sv
hdl/pareto_front_archive.sv
hdl/pfa_checker.sv
tb/sv/tb_pareto_front_archive.sv
